@@ sv/dit_pkg.sv @@
// Package for the disjoint interval tracker: operation, kind and status codes,
// the cell command type and field widths. No dependencies.
`default_nettype none

package dit_pkg;

    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 6;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_DUMP = 1'b1;

    localparam logic KIND_STATUS   = 1'b0;
    localparam logic KIND_INTERVAL = 1'b1;

    localparam logic [STATUS_W-1:0] ST_COVERED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXTENDED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_JOINED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd4;

    typedef enum logic [6:0] {
        OP_HOLD      = 7'b0000001,
        OP_CMP       = 7'b0000010,
        OP_JOIN      = 7'b0000100,
        OP_EXT_LEFT  = 7'b0001000,
        OP_EXT_RIGHT = 7'b0010000,
        OP_INSERT    = 7'b0100000,
        OP_ROTATE    = 7'b1000000
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     occ;
        logic     tail;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ sv/dit_if.sv @@
// Valid/ready channel interfaces for the disjoint interval tracker.
// Depends on dit_pkg for the status and total widths.
`default_nettype none

interface dit_in_if #(parameter int VALUE_BITS = 31);
    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, func, value, input ready);
    modport sink   (input valid, func, value, output ready);
endinterface

interface dit_out_if #(parameter int VALUE_BITS = 31);
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [dit_pkg::STATUS_W-1:0] status;
    logic                         interval_valid;
    logic [VALUE_BITS-1:0]        low_bound;
    logic [VALUE_BITS-1:0]        high_bound;
    logic [dit_pkg::TOTAL_W-1:0]  interval_total;
    logic                         last;

    modport source (output valid, kind, status, interval_valid, low_bound, high_bound,
                    interval_total, last, input ready);
    modport sink   (input valid, kind, status, interval_valid, low_bound, high_bound,
                    interval_total, last, output ready);
endinterface

`default_nettype wire

@@ sv/dit_cell.sv @@
// One cell of the interval chain: holds one interval, compares it with the
// broadcast value and moves data to or from its neighbours. Depends on dit_pkg.
`default_nettype none

module dit_cell #(
    parameter int VALUE_BITS = 31
) (
    input  wire logic                  i_clk,
    input  wire dit_pkg::t_cell_ctl    i_ctl,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic                  i_left_lt,
    input  wire logic [VALUE_BITS-1:0] i_left_start,
    input  wire logic [VALUE_BITS-1:0] i_left_end,
    input  wire logic                  i_right_lt,
    input  wire logic [VALUE_BITS-1:0] i_right_start,
    input  wire logic [VALUE_BITS-1:0] i_right_end,
    input  wire logic [VALUE_BITS-1:0] i_head_start,
    input  wire logic [VALUE_BITS-1:0] i_head_end,
    output logic      [VALUE_BITS-1:0] o_start,
    output logic      [VALUE_BITS-1:0] o_end,
    output logic                       o_lt,
    output logic                       o_cov,
    output logic                       o_eqe,
    output logic                       o_eqs
);
    import dit_pkg::*;

    logic [VALUE_BITS-1:0] r_start, n_start;
    logic [VALUE_BITS-1:0] r_end, n_end;
    logic                  r_lt, n_lt;
    logic                  r_cov, n_cov;
    logic                  r_eqe, n_eqe;
    logic                  r_eqs, n_eqs;
    logic [VALUE_BITS-1:0] v_dec;
    logic [VALUE_BITS-1:0] v_inc;
    logic                  v_zero;
    logic                  v_top;

    assign v_dec  = i_value - VALUE_BITS'(1);
    assign v_inc  = i_value + VALUE_BITS'(1);
    assign v_zero = (i_value == '0);
    assign v_top  = (i_value == '1);

    always_comb begin
        n_start = r_start;
        n_end   = r_end;
        n_lt    = r_lt;
        n_cov   = r_cov;
        n_eqe   = r_eqe;
        n_eqs   = r_eqs;
        case (i_ctl.op)
            OP_CMP: begin
                n_lt  = i_ctl.occ && (r_start < i_value);
                n_cov = i_ctl.occ && (r_start <= i_value) && (r_end >= i_value);
                n_eqe = i_ctl.occ && !v_zero && (r_end == v_dec);
                n_eqs = i_ctl.occ && !v_top && (r_start == v_inc);
            end
            OP_JOIN: begin
                if (r_lt && !i_right_lt) begin
                    n_end = i_right_end;
                end else if (!r_lt) begin
                    n_start = i_right_start;
                    n_end   = i_right_end;
                end
            end
            OP_EXT_LEFT: begin
                if (r_lt && !i_right_lt) begin
                    n_end = i_value;
                end
            end
            OP_EXT_RIGHT: begin
                if (!r_lt && i_left_lt) begin
                    n_start = i_value;
                end
            end
            OP_INSERT: begin
                if (!r_lt && i_left_lt) begin
                    n_start = i_value;
                    n_end   = i_value;
                end else if (!r_lt) begin
                    n_start = i_left_start;
                    n_end   = i_left_end;
                end
            end
            OP_ROTATE: begin
                if (i_ctl.occ) begin
                    n_start = i_ctl.tail ? i_head_start : i_right_start;
                    n_end   = i_ctl.tail ? i_head_end : i_right_end;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_end   <= n_end;
        r_lt    <= n_lt;
        r_cov   <= n_cov;
        r_eqe   <= n_eqe;
        r_eqs   <= n_eqs;
    end

    assign o_start = r_start;
    assign o_end   = r_end;
    assign o_lt    = r_lt;
    assign o_cov   = r_cov;
    assign o_eqe   = r_eqe;
    assign o_eqs   = r_eqs;

endmodule

`default_nettype wire

@@ sv/disjoint_interval_tracker.sv @@
// Disjoint interval tracker: a chain of cells holding sorted disjoint intervals.
// An add result is registered after a compare in every cell (S_CMP) and then one shift
// step (S_UPD); no new transaction is accepted until the add or dump is finished. A dump
// emits one result per cycle, one per interval or a single one if empty; a stalled result
// holds the chain, and the add step waits too. Reset clears the count, control state and
// output valid, not the intervals. Depends on dit_pkg, dit_if.
`default_nettype none

module disjoint_interval_tracker #(
    parameter int MAX_INTERVALS = 32,
    parameter int VALUE_BITS    = 31
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dit_in_if.sink     i_in,
    dit_out_if.source  o_out
);
    import dit_pkg::*;

    localparam int N  = MAX_INTERVALS;
    localparam int CW = $clog2(MAX_INTERVALS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_UPD  = 4'b0100,
        S_DUMP = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_left, n_left;
    logic                  r_ov, n_ov;
    logic                  r_kind, n_kind;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic                  r_ivalid, n_ivalid;
    logic [VALUE_BITS-1:0] r_lo, n_lo;
    logic [VALUE_BITS-1:0] r_hi, n_hi;
    logic [TOTAL_W-1:0]    r_total, n_total;
    logic                  r_last, n_last;

    t_cell_op              cell_op;
    t_cell_op              add_op;
    logic [STATUS_W-1:0]   add_status;
    logic [CW-1:0]         add_count;
    logic                  out_free;
    logic                  in_acc;
    logic                  covered;
    logic                  touch_left;
    logic                  touch_right;
    logic                  full;

    logic [VALUE_BITS-1:0] c_start [N];
    logic [VALUE_BITS-1:0] c_end [N];
    logic [N-1:0]          c_lt;
    logic [N-1:0]          c_cov;
    logic [N-1:0]          c_eqe;
    logic [N-1:0]          c_eqs;

    assign out_free    = !r_ov || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && (r_state == S_IDLE);
    assign covered     = |c_cov;
    assign touch_left  = |c_eqe;
    assign touch_right = |c_eqs;
    assign full        = (r_count == CW'(N));

    for (genvar g = 0; g < N; g++) begin : g_cell
        t_cell_ctl             ctl;
        logic                  left_lt;
        logic [VALUE_BITS-1:0] left_start;
        logic [VALUE_BITS-1:0] left_end;
        logic                  right_lt;
        logic [VALUE_BITS-1:0] right_start;
        logic [VALUE_BITS-1:0] right_end;

        assign ctl.op   = cell_op;
        assign ctl.occ  = (CW'(g) < r_count);
        assign ctl.tail = (CW'(g + 1) == r_count);

        if (g == 0) begin : g_first
            assign left_lt    = 1'b1;
            assign left_start = '0;
            assign left_end   = '0;
        end else begin : g_mid_l
            assign left_lt    = c_lt[g-1];
            assign left_start = c_start[g-1];
            assign left_end   = c_end[g-1];
        end

        if (g == N - 1) begin : g_last
            assign right_lt    = 1'b0;
            assign right_start = '0;
            assign right_end   = '0;
        end else begin : g_mid_r
            assign right_lt    = c_lt[g+1];
            assign right_start = c_start[g+1];
            assign right_end   = c_end[g+1];
        end

        dit_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_value       (r_value),
            .i_left_lt     (left_lt),
            .i_left_start  (left_start),
            .i_left_end    (left_end),
            .i_right_lt    (right_lt),
            .i_right_start (right_start),
            .i_right_end   (right_end),
            .i_head_start  (c_start[0]),
            .i_head_end    (c_end[0]),
            .o_start       (c_start[g]),
            .o_end         (c_end[g]),
            .o_lt          (c_lt[g]),
            .o_cov         (c_cov[g]),
            .o_eqe         (c_eqe[g]),
            .o_eqs         (c_eqs[g])
        );
    end

    always_comb begin
        add_op     = OP_HOLD;
        add_status = ST_COVERED;
        add_count  = r_count;
        if (covered) begin
            add_status = ST_COVERED;
        end else if (touch_left && touch_right) begin
            add_op     = OP_JOIN;
            add_status = ST_JOINED;
            add_count  = r_count - CW'(1);
        end else if (touch_left) begin
            add_op     = OP_EXT_LEFT;
            add_status = ST_EXTENDED;
        end else if (touch_right) begin
            add_op     = OP_EXT_RIGHT;
            add_status = ST_EXTENDED;
        end else if (full) begin
            add_status = ST_DROPPED;
        end else begin
            add_op     = OP_INSERT;
            add_status = ST_INSERTED;
            add_count  = r_count + CW'(1);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_value  = r_value;
        n_count  = r_count;
        n_left   = r_left;
        n_ov     = r_ov && !o_out.ready;
        n_kind   = r_kind;
        n_status = r_status;
        n_ivalid = r_ivalid;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_total  = r_total;
        n_last   = r_last;
        cell_op  = OP_HOLD;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_value = i_in.value;
                    n_left  = r_count;
                    n_state = (i_in.func == FUNC_ADD) ? S_CMP : S_DUMP;
                end
            end
            S_CMP: begin
                cell_op = OP_CMP;
                n_state = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    cell_op  = add_op;
                    n_count  = add_count;
                    n_ov     = 1'b1;
                    n_kind   = KIND_STATUS;
                    n_status = add_status;
                    n_ivalid = 1'b0;
                    n_lo     = '0;
                    n_hi     = '0;
                    n_total  = TOTAL_W'(add_count);
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_kind   = KIND_INTERVAL;
                    n_status = ST_COVERED;
                    n_total  = TOTAL_W'(r_count);
                    if (r_left == '0) begin
                        n_ivalid = 1'b0;
                        n_lo     = '0;
                        n_hi     = '0;
                        n_last   = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        cell_op  = OP_ROTATE;
                        n_ivalid = 1'b1;
                        n_lo     = c_start[0];
                        n_hi     = c_end[0];
                        n_last   = (r_left == CW'(1));
                        n_left   = r_left - CW'(1);
                        if (r_left == CW'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_left  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_kind   <= n_kind;
        r_status <= n_status;
        r_ivalid <= n_ivalid;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_total  <= n_total;
        r_last   <= n_last;
    end

    assign o_out.valid          = r_ov;
    assign o_out.kind           = r_kind;
    assign o_out.status         = r_status;
    assign o_out.interval_valid = r_ivalid;
    assign o_out.low_bound      = r_lo;
    assign o_out.high_bound     = r_hi;
    assign o_out.interval_total = r_total;
    assign o_out.last           = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(N))
        else $error("Interval count exceeds the table depth.");

    a_single_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $onehot0(c_cov))
        else $error("More than one interval covers the same value.");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && out_free && add_status == ST_DROPPED) |-> full)
        else $error("A value was dropped while the table had room.");

    a_join_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && out_free && add_op == OP_JOIN)
        |=> (r_count == $past(r_count) - CW'(1)))
        else $error("A join did not remove exactly one interval.");

endmodule

`default_nettype wire
